// ----- src/present128_key_schedule_top_defines.svh -----
// Assertion helpers shared by the key schedule RTL.
`ifndef PRESENT128_KEY_SCHEDULE_TOP_DEFINES_SVH
`define PRESENT128_KEY_SCHEDULE_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define P128KS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define P128KS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- src/p128ks_pkg.sv -----
`default_nettype none

package p128ks_pkg;

   localparam int unsigned HALF_W  = 64;
   localparam int unsigned INDEX_W = 5;

   typedef logic [HALF_W-1:0]  key_half_type;
   typedef logic [INDEX_W-1:0] round_index_type;
   typedef logic [3:0]         nibble_type;

   typedef struct packed {
      key_half_type hi;
      key_half_type lo;
   } key_state_type;

   typedef nibble_type sbox_array_type [16];

   localparam sbox_array_type SBOX = '{
      4'hC, 4'h5, 4'h6, 4'hB, 4'h9, 4'h0, 4'hA, 4'hD,
      4'h3, 4'hE, 4'hF, 4'h8, 4'h4, 4'h7, 4'h1, 4'h2
   };

   // One schedule round: rotate left by 61, S-box the top two nibbles,
   // fold the round counter into bits 66..62.
   function automatic key_state_type schedule_round(key_state_type cur,
                                                    round_index_type ctr);
      key_state_type nxt;
      nxt.hi = {cur.hi[2:0], cur.lo[HALF_W-1:3]};
      nxt.lo = {cur.lo[2:0], cur.hi[HALF_W-1:3]};
      nxt.hi[HALF_W-1 -: 4] = SBOX[nxt.hi[HALF_W-1 -: 4]];
      nxt.hi[HALF_W-5 -: 4] = SBOX[nxt.hi[HALF_W-5 -: 4]];
      nxt.hi[2:0] = nxt.hi[2:0] ^ ctr[4:2];
      nxt.lo[HALF_W-1 -: 2] = nxt.lo[HALF_W-1 -: 2] ^ ctr[1:0];
      return nxt;
   endfunction

endpackage

`default_nettype wire

// ----- src/p128ks_if.sv -----
`default_nettype none

// Key channel: one transaction carries a full 128-bit key.
interface p128ks_req_if import p128ks_pkg::*; ();
   logic         valid;
   logic         ready;
   key_half_type key_high;
   key_half_type key_low;

   modport source (output valid, output key_high, output key_low, input ready);
   modport sink   (input valid, input key_high, input key_low, output ready);
endinterface

// Subkey channel: one transaction per round subkey.
interface p128ks_rsp_if import p128ks_pkg::*; ();
   logic            valid;
   logic            ready;
   key_half_type    subkey;
   round_index_type round_index;
   logic            last;

   modport source (output valid, output subkey, output round_index, output last,
                   input ready);
   modport sink   (input valid, input subkey, input round_index, input last,
                   output ready);
endinterface

`default_nettype wire

// ----- src/present128_key_schedule_top.sv -----
// PRESENT-128 key schedule.
// req_if takes a 128-bit key (key_high = bits 127..64, key_low = 63..0) as
// one valid/ready transaction. rsp_if then delivers NUM_SUBKEYS subkeys in
// order, each with its round_index (0 first) and last set on the final one.
// Latency: subkey 0 is valid the cycle after the key is accepted.
// Throughput: one subkey per cycle when the receiver never stalls. The
// figure comes from the single schedule-round unit that updates the
// 128-bit key register once per delivered subkey.
// The next key is accepted in the same cycle the last subkey is taken, so
// runs follow each other with no gap.
// The key register doubles as the output register: a stall on rsp_if
// (ready low) freezes it, holding the current subkey stable, and req_if
// stays not ready until the run's last subkey is taken.
// Synchronous active-high reset drops rsp_if valid and makes req_if ready;
// any run in progress is discarded.
`default_nettype none
`include "present128_key_schedule_top_defines.svh"

module present128_key_schedule_top import p128ks_pkg::*; #(
   parameter int unsigned NUM_SUBKEYS = 32
) (
   input  wire logic      clock,
   input  wire logic      reset,
   p128ks_req_if.sink     req_if,
   p128ks_rsp_if.source   rsp_if
);

   localparam round_index_type LAST_INDEX = INDEX_W'(NUM_SUBKEYS - 1);

   key_state_type   key_ff, key_in;
   round_index_type idx_ff, idx_in;
   logic            busy_ff, busy_in;

   logic key_acc;
   logic rsp_acc;
   logic at_last;

   assign at_last = (idx_ff == LAST_INDEX);
   assign rsp_acc = busy_ff && rsp_if.ready;

   // Free, or the final subkey leaves this cycle.
   assign req_if.ready = !busy_ff || (rsp_acc && at_last);
   assign key_acc      = req_if.valid && req_if.ready;

   always_comb begin
      key_in  = key_ff;
      idx_in  = idx_ff;
      busy_in = busy_ff;
      if (key_acc) begin
         key_in.hi = req_if.key_high;
         key_in.lo = req_if.key_low;
         idx_in    = '0;
         busy_in   = 1'b1;
      end else if (rsp_acc) begin
         if (at_last) begin
            busy_in = 1'b0;
         end else begin
            idx_in = idx_ff + 1'b1;
            key_in = schedule_round(key_ff, idx_ff + 1'b1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

   assign rsp_if.valid       = busy_ff;
   assign rsp_if.subkey      = key_ff.hi;
   assign rsp_if.round_index = idx_ff;
   assign rsp_if.last        = at_last;

   `P128KS_ASSERT_NOW(a_accept_only_at_end, clock, reset,
      key_acc && busy_ff, rsp_acc && at_last,
      "key accepted while a run is still in progress")
   `P128KS_ASSERT_NEXT(a_first_subkey, clock, reset,
      key_acc,
      rsp_if.valid && rsp_if.round_index == '0 && rsp_if.subkey == $past(req_if.key_high),
      "first subkey is not the key's upper half")
   `P128KS_ASSERT_NEXT(a_index_steps, clock, reset,
      rsp_acc && !at_last,
      rsp_if.valid && rsp_if.round_index == INDEX_W'($past(idx_ff) + 1'b1),
      "round index did not advance by one")
   `P128KS_ASSERT_NEXT(a_run_ends, clock, reset,
      rsp_acc && at_last && !key_acc,
      !rsp_if.valid,
      "subkeys continue past the last one")

endmodule

`default_nettype wire

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
   import p128ks_pkg::*;

   localparam int SUBKEY_COUNT = 32;
   localparam int RANDOM_KEYS  = 200;
   localparam int IDLE_LIMIT   = 2000;
   localparam int REPORT_MAX   = 10;
   localparam int MAX_GAP      = 45;
   localparam int MAX_BURST    = 6;

   typedef struct packed {
      key_half_type    subkey;
      round_index_type round_index;
      logic            last;
   } subkey_txn_type;

   // sk1_known: subkey 1 is typed in instead of taken from the predictor
   typedef struct packed {
      key_half_type key_high;
      key_half_type key_low;
      logic         sk1_known;
      key_half_type sk1;
   } key_row_type;

   localparam int KEY_ROWS = 14;
   localparam key_row_type KEY_TABLE [KEY_ROWS] = '{
      '{64'h0000_0000_0000_0000, 64'h0000_0000_0000_0000, 1'b1, 64'hCC00_0000_0000_0000},
      '{64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 64'h22FF_FFFF_FFFF_FFFF},
      '{64'h8000_0000_0000_0000, 64'h0000_0000_0000_0000, 1'b0, 64'h0},
      '{64'h0000_0000_0000_0000, 64'h0000_0000_0000_0001, 1'b0, 64'h0},
      '{64'h0000_0000_0000_0000, 64'h8000_0000_0000_0000, 1'b0, 64'h0},
      '{64'h0000_0000_0000_0001, 64'h0000_0000_0000_0000, 1'b0, 64'h0},
      '{64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 64'h0},
      '{64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 1'b0, 64'h0},
      '{64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0000, 1'b0, 64'h0},
      '{64'h0000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 64'h0},
      '{64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 1'b0, 64'h0},
      // same key again: a new run must not depend on the previous one
      '{64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 1'b0, 64'h0},
      // bits that the round counter folds into
      '{64'h0000_0000_0000_0007, 64'hC000_0000_0000_0000, 1'b0, 64'h0},
      '{64'h00FF_FFFF_FFFF_FFFF, 64'hFF00_0000_0000_0000, 1'b0, 64'h0}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   p128ks_req_if req_if ();
   p128ks_rsp_if rsp_if ();

   present128_key_schedule_top #(.NUM_SUBKEYS(SUBKEY_COUNT)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   always #6 clock = ~clock;

   subkey_txn_type subkey_q [$];
   int unsigned fault_count = 0;
   int unsigned idle_cycles = 0;
   logic [15:0] stall_pattern = 16'hFFFF;
   int unsigned pattern_age   = 0;

   function automatic logic [3:0] sbox_nibble(input logic [3:0] n);
      case (n)
         4'h0: return 4'hC;
         4'h1: return 4'h5;
         4'h2: return 4'h6;
         4'h3: return 4'hB;
         4'h4: return 4'h9;
         4'h5: return 4'h0;
         4'h6: return 4'hA;
         4'h7: return 4'hD;
         4'h8: return 4'h3;
         4'h9: return 4'hE;
         4'hA: return 4'hF;
         4'hB: return 4'h8;
         4'hC: return 4'h4;
         4'hD: return 4'h7;
         4'hE: return 4'h1;
         default: return 4'h2;
      endcase
   endfunction

   function automatic logic [127:0] next_key_reg(input logic [127:0] w,
                                                 input round_index_type ctr);
      logic [127:0] r;
      r = {w[66:0], w[127:67]};
      r[127:124] = sbox_nibble(r[127:124]);
      r[123:120] = sbox_nibble(r[123:120]);
      r[66:62]   = r[66:62] ^ ctr;
      return r;
   endfunction

   task automatic push_subkeys(input key_half_type kh, input key_half_type kl,
                               input logic sk1_known, input key_half_type sk1);
      logic [127:0]   kreg;
      subkey_txn_type rec;
      int             k;
      kreg = {kh, kl};
      for (k = 0; k < SUBKEY_COUNT; k++) begin
         if (k > 0)
            kreg = next_key_reg(kreg, round_index_type'(k));
         rec.subkey      = (k == 1 && sk1_known) ? sk1 : kreg[127:64];
         rec.round_index = round_index_type'(k);
         rec.last        = (k == SUBKEY_COUNT - 1);
         subkey_q.push_back(rec);
      end
   endtask

   task automatic send_key(input key_half_type kh, input key_half_type kl,
                           input logic sk1_known, input key_half_type sk1);
      req_if.valid    <= 1'b1;
      req_if.key_high <= kh;
      req_if.key_low  <= kl;
      do @(posedge clock); while (!(req_if.valid && req_if.ready));
      push_subkeys(kh, kl, sk1_known, sk1);
   endtask

   task automatic take_gap(input int unsigned cycles);
      req_if.valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // hold the key channel until every pending subkey has drained
   task automatic settle_all();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (subkey_q.size() != 0);
   endtask

   always @(posedge clock) begin : check_subkeys
      subkey_txn_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (subkey_q.size() == 0) begin
            if (fault_count < REPORT_MAX)
               $display("unexpected subkey transaction: subkey %h idx %0d last %b",
                        rsp_if.subkey, rsp_if.round_index, rsp_if.last);
            fault_count++;
         end else begin
            want = subkey_q.pop_front();
            if (want.subkey !== rsp_if.subkey || want.round_index !== rsp_if.round_index ||
                want.last !== rsp_if.last) begin
               if (fault_count < REPORT_MAX)
                  $display("subkey mismatch: expected %h idx %0d last %b, got %h idx %0d last %b",
                           want.subkey, want.round_index, want.last,
                           rsp_if.subkey, rsp_if.round_index, rsp_if.last);
               fault_count++;
            end
         end
      end
   end

   // receiver stalls follow a rotating 16-bit mask, reloaded whenever pattern_age wraps to zero
   always @(posedge clock) begin : drive_ready
      if (pattern_age == 0) begin
         case ($urandom_range(3))
            0: stall_pattern = 16'hFFFF;
            1: stall_pattern = 16'($urandom) | 16'h0001;
            2: stall_pattern = 16'($urandom & $urandom) | 16'h0001;
            default: stall_pattern = 16'($urandom | $urandom) | 16'h0001;
         endcase
      end
      rsp_if.ready  <= stall_pattern[0];
      stall_pattern  = {stall_pattern[0], stall_pattern[15:1]};
      pattern_age    = (pattern_age + 1) % 128;
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == IDLE_LIMIT) begin
         $display("present128_key_schedule_top verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus
      key_half_type kh;
      key_half_type kl;
      int           burst_left;
      int           i;
      req_if.valid    <= 1'b0;
      req_if.key_high <= '0;
      req_if.key_low  <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      burst_left = $urandom_range(1, MAX_BURST);

      for (i = 0; i < KEY_ROWS; i++) begin
         if (burst_left <= 0) begin
            take_gap($urandom_range(1, MAX_GAP));
            burst_left = $urandom_range(1, MAX_BURST);
         end
         send_key(KEY_TABLE[i].key_high, KEY_TABLE[i].key_low,
                  KEY_TABLE[i].sk1_known, KEY_TABLE[i].sk1);
         burst_left--;
      end
      settle_all();

      for (i = 0; i < RANDOM_KEYS; i++) begin
         if (i == RANDOM_KEYS / 2) begin
            settle_all();
            burst_left = $urandom_range(1, MAX_BURST);
         end else if (burst_left <= 0) begin
            take_gap($urandom_range(1, MAX_GAP));
            burst_left = $urandom_range(1, MAX_BURST);
         end
         kh = {$urandom, $urandom};
         kl = {$urandom, $urandom};
         case ($urandom_range(9))
            0: kh = '0;
            1: kh = '1;
            2: kl = '0;
            3: kl = '1;
            default: ;
         endcase
         send_key(kh, kl, 1'b0, '0);
         burst_left--;
      end
      settle_all();
      repeat (64) @(posedge clock);

      if (fault_count == 0)
         $display("present128_key_schedule_top verification clean");
      else
         $display("present128_key_schedule_top verification failed");
      $finish;
   end

endmodule
